### design/tw_pkg.sv
`timescale 1ns / 1ps
// Package for the 3-Way block cipher: word types, round constants, theta and mu.
// Depends on nothing; used by tw_round and threeway_block_cipher.
package tw_pkg;

    localparam int unsigned ROUNDS  = 11;
    localparam int unsigned LATENCY = ROUNDS + 2;

    localparam logic [15:0] START_ENC = 16'h0B0B;
    localparam logic [15:0] START_DEC = 16'hB1B1;
    localparam logic [16:0] LFSR_POLY = 17'h11011;
    localparam logic [16:0] LFSR_TOP  = 17'h10000;

    localparam int unsigned ADDR_W = 4;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_KEY_0 = 2'd0;
    localparam logic [1:0] REG_KEY_1 = 2'd1;
    localparam logic [1:0] REG_KEY_2 = 2'd2;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Element [0] is word 0 (bytes 0..3)
    typedef logic [2:0][31:0] block_t;

    typedef struct packed {
        logic        command;
        logic [31:0] data_word_0;
        logic [31:0] data_word_1;
        logic [31:0] data_word_2;
    } data_t;

    typedef struct packed {
        logic [31:0] result_word_0;
        logic [31:0] result_word_1;
        logic [31:0] result_word_2;
    } result_t;

    // One pipeline stage: valid bit, command and block travel together
    typedef struct packed {
        logic   valid;
        logic   command;
        block_t block;
    } stage_t;

    function automatic logic [15:0] rc_next(input logic [15:0] s);
        logic [16:0] t;
        t = {s, 1'b0};
        if ((t & LFSR_TOP) != 17'd0)
        begin
            t = t ^ LFSR_POLY;
        end
        return t[15:0];
    endfunction

    // Round constant after a given number of LFSR steps from the seed (at most 16 steps)
    function automatic logic [15:0] rc_at(input logic [15:0] seed, input int unsigned steps);
        logic [15:0] s;
        s = seed;
        for (int unsigned i = 0; i < 16; i++)
        begin
            if (i < steps)
            begin
                s = rc_next(s);
            end
        end
        return s;
    endfunction

    function automatic logic [31:0] theta_word(input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z);
        return x ^ (x >> 16) ^ (y << 16) ^ (y >> 16) ^ (z << 16) ^
               (y >> 24) ^ (z << 8) ^ (z >> 8) ^ (x << 24) ^ (z >> 16) ^
               (x << 16) ^ (z >> 24) ^ (x << 8);
    endfunction

    function automatic block_t theta(input block_t w);
        block_t r;
        r[0] = theta_word(w[0], w[1], w[2]);
        r[1] = theta_word(w[1], w[2], w[0]);
        r[2] = theta_word(w[2], w[0], w[1]);
        return r;
    endfunction

    function automatic logic [31:0] rev32(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
        begin
            r[i] = x[31 - i];
        end
        return r;
    endfunction

    // mu: reverse the whole 96-bit block
    function automatic block_t mu(input block_t w);
        block_t r;
        r[0] = rev32(w[2]);
        r[1] = rev32(w[1]);
        r[2] = rev32(w[0]);
        return r;
    endfunction

endpackage

### design/tw_round.sv
`timescale 1ns / 1ps
// One registered 3-Way round: key and constant add, theta, pi_1, gamma, pi_2.
// Depends on tw_pkg.
module tw_round (
    input  logic            clk,
    input  logic            rst_n,
    input  tw_pkg::stage_t  stage_in,
    input  tw_pkg::block_t  key_enc,
    input  tw_pkg::block_t  key_dec,
    input  logic [15:0]     rc_enc,
    input  logic [15:0]     rc_dec,
    output tw_pkg::stage_t  stage_out
);

    tw_pkg::block_t key;
    logic [15:0]    rc;
    tw_pkg::block_t keyed;
    tw_pkg::block_t mixed;
    tw_pkg::block_t rot1;
    tw_pkg::block_t nonlin;
    tw_pkg::block_t round_next;
    logic           valid_reg;
    logic           command_reg;
    tw_pkg::block_t block_reg;

    always_comb
    begin
        key = (stage_in.command == tw_pkg::CMD_DECRYPT) ? key_dec : key_enc;
        rc  = (stage_in.command == tw_pkg::CMD_DECRYPT) ? rc_dec : rc_enc;

        keyed[0] = stage_in.block[0] ^ key[0] ^ {rc, 16'h0000};
        keyed[1] = stage_in.block[1] ^ key[1];
        keyed[2] = stage_in.block[2] ^ key[2] ^ {16'h0000, rc};

        mixed = tw_pkg::theta(keyed);

        rot1[0] = {mixed[0][9:0], mixed[0][31:10]};
        rot1[1] = mixed[1];
        rot1[2] = {mixed[2][30:0], mixed[2][31]};

        nonlin[0] = rot1[0] ^ (rot1[1] | ~rot1[2]);
        nonlin[1] = rot1[1] ^ (rot1[2] | ~rot1[0]);
        nonlin[2] = rot1[2] ^ (rot1[0] | ~rot1[1]);

        round_next[0] = {nonlin[0][30:0], nonlin[0][31]};
        round_next[1] = nonlin[1];
        round_next[2] = {nonlin[2][9:0], nonlin[2][31:10]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        command_reg <= stage_in.command;
        block_reg   <= round_next;
    end

    assign stage_out = '{valid: valid_reg, command: command_reg, block: block_reg};

    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        stage_in.valid |=> stage_out.valid)
        else $error("round stage dropped a valid word");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_in.valid |=> !stage_out.valid)
        else $error("round stage invented a word");

    a_command_follows: assert property (@(posedge clk) disable iff (!rst_n)
        stage_in.valid |=> (stage_out.command == $past(stage_in.command)))
        else $error("round stage lost the command bit");

endmodule

### design/threeway_block_cipher.sv
`timescale 1ns / 1ps
// Top level of the pipelined 3-Way block cipher with its APB key registers.
// Depends on tw_pkg and tw_round.
//
//   channel   handshake            payload
//   -------   ------------------   --------------------------------------------
//   input     start / busy         data   : command, data_word_0..2
//   output    done (strobe)        result : result_word_0..2
//   config    psel/penable/pready  paddr, pwdata, prdata : key_word_0..2
//
// The accepting edge loads the input stage, then eleven round stages and one output
// stage follow; done and the result are registered together in the output stage.
// A new word enters every cycle; busy stays low, so throughput is
// one block per clock. Reset clears the valid bits of every stage and the key
// registers. The receiver cannot stall, so the pipeline never holds; each result
// shows for exactly one cycle.
module threeway_block_cipher (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tw_pkg::data_t               data,
    output logic                        done,
    output tw_pkg::result_t             result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tw_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // Key registers
    logic [31:0]    key_word_0_reg;
    logic [31:0]    key_word_1_reg;
    logic [31:0]    key_word_2_reg;
    logic [1:0]     reg_index;
    logic           cfg_write;
    tw_pkg::block_t key_enc;
    tw_pkg::block_t key_dec;

    // Pipeline
    tw_pkg::stage_t stage [tw_pkg::ROUNDS + 1];
    logic           in_valid_reg;
    logic           in_command_reg;
    tw_pkg::block_t in_block_reg;
    tw_pkg::block_t in_block_next;

    // Output stage
    tw_pkg::block_t final_keyed;
    tw_pkg::block_t final_mixed;
    tw_pkg::block_t final_next;
    tw_pkg::block_t last_key;
    logic [15:0]    last_rc;
    logic           done_reg;
    logic           out_command_reg;
    tw_pkg::block_t result_reg;

    localparam logic [15:0] FINAL_RC_ENC = tw_pkg::rc_at(tw_pkg::START_ENC, tw_pkg::ROUNDS);
    localparam logic [15:0] FINAL_RC_DEC = tw_pkg::rc_at(tw_pkg::START_DEC, tw_pkg::ROUNDS);

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_word_0_reg <= 32'd0;
            key_word_1_reg <= 32'd0;
            key_word_2_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                tw_pkg::REG_KEY_0: key_word_0_reg <= pwdata;
                tw_pkg::REG_KEY_1: key_word_1_reg <= pwdata;
                tw_pkg::REG_KEY_2: key_word_2_reg <= pwdata;
                default:           ;  // drop writes past the last register
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            tw_pkg::REG_KEY_0: prdata = key_word_0_reg;
            tw_pkg::REG_KEY_1: prdata = key_word_1_reg;
            tw_pkg::REG_KEY_2: prdata = key_word_2_reg;
            default:           prdata = 32'd0;
        endcase
    end

    // Decrypt key is theta then mu of the stored key. The user must change the key only while the
    // pipeline is empty (the block does not enforce it), so every stage reads it straight from the registers.
    assign key_enc = {key_word_2_reg, key_word_1_reg, key_word_0_reg};
    assign key_dec = tw_pkg::mu(tw_pkg::theta(key_enc));

    // ---------------------------------------------------------------- input stage
    // The pipeline never holds, so accept a word every cycle.
    assign busy = 1'b0;

    always_comb
    begin
        in_block_next = {data.data_word_2, data.data_word_1, data.data_word_0};
        // Bit-reverse the block on the way in to decrypt
        if (data.command == tw_pkg::CMD_DECRYPT)
        begin
            in_block_next = tw_pkg::mu(in_block_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_command_reg <= data.command;
        in_block_reg   <= in_block_next;
    end

    assign stage[0] = '{valid: in_valid_reg, command: in_command_reg, block: in_block_reg};

    // ---------------------------------------------------------------- round stages
    // One registered stage per round; round constants are fixed per stage.
    for (genvar r = 0; r < tw_pkg::ROUNDS; r++)
    begin : g_round
        localparam logic [15:0] RC_ENC = tw_pkg::rc_at(tw_pkg::START_ENC, r);
        localparam logic [15:0] RC_DEC = tw_pkg::rc_at(tw_pkg::START_DEC, r);

        tw_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (stage[r]),
            .key_enc   (key_enc),
            .key_dec   (key_dec),
            .rc_enc    (RC_ENC),
            .rc_dec    (RC_DEC),
            .stage_out (stage[r + 1])
        );
    end

    // ---------------------------------------------------------------- output stage
    // Final key and constant add, theta, then undo the bit reversal to decrypt.
    always_comb
    begin
        if (stage[tw_pkg::ROUNDS].command == tw_pkg::CMD_DECRYPT)
        begin
            last_key = key_dec;
            last_rc  = FINAL_RC_DEC;
        end
        else
        begin
            last_key = key_enc;
            last_rc  = FINAL_RC_ENC;
        end

        final_keyed[0] = stage[tw_pkg::ROUNDS].block[0] ^ last_key[0] ^ {last_rc, 16'h0000};
        final_keyed[1] = stage[tw_pkg::ROUNDS].block[1] ^ last_key[1];
        final_keyed[2] = stage[tw_pkg::ROUNDS].block[2] ^ last_key[2] ^ {16'h0000, last_rc};

        final_mixed = tw_pkg::theta(final_keyed);
        final_next  = final_mixed;
        if (stage[tw_pkg::ROUNDS].command == tw_pkg::CMD_DECRYPT)
        begin
            final_next = tw_pkg::mu(final_mixed);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage[tw_pkg::ROUNDS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_command_reg <= stage[tw_pkg::ROUNDS].command;
        result_reg      <= final_next;
    end

    assign done   = done_reg;
    assign result = '{result_word_0: result_reg[0],
                      result_word_1: result_reg[1],
                      result_word_2: result_reg[2]};

    // ---------------------------------------------------------------- checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(tw_pkg::LATENCY) done)
        else $error("accepted word did not come out after the pipeline latency");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##(tw_pkg::LATENCY) !done)
        else $error("result strobe without an accepted word");

    a_command_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(tw_pkg::LATENCY)
            (out_command_reg == $past(data.command, tw_pkg::LATENCY)))
        else $error("command bit lost through the pipeline");

endmodule
